>>> rtl/core/mts_pkg.sv
// Shared types, constants and lookup tables of the melody tone sequencer.
package mts_pkg;

  localparam int SongDepth = 64;
  localparam int SongIdxW  = $clog2(SongDepth);
  localparam int CmdDepth  = 4;
  localparam int CmdPtrW   = $clog2(CmdDepth);
  localparam int OutDepth  = 4;
  localparam int OutPtrW   = $clog2(OutDepth);
  localparam int TuneLen   = 43;

  localparam logic [1:0] CmdTick  = 2'd0;
  localparam logic [1:0] CmdByte  = 2'd1;
  localparam logic [1:0] CmdWrite = 2'd2;

  localparam logic [7:0] CharPLower = 8'h70;
  localparam logic [7:0] CharPUpper = 8'h50;

  localparam logic [1:0] CfgPwmLoad    = 2'd0;
  localparam logic [1:0] CfgNoteUnit   = 2'd1;
  localparam logic [1:0] CfgRestTicks  = 2'd2;
  localparam logic [1:0] CfgSongLength = 2'd3;

  localparam logic [15:0] PwmLoadReset    = 16'd399;
  localparam logic [15:0] NoteUnitReset   = 16'd800;
  localparam logic [15:0] RestTicksReset  = 16'd800;
  localparam logic [6:0]  SongLengthReset = 7'd43;

  localparam logic [1:0] LedOff   = 2'd0;
  localparam logic [1:0] LedRed   = 2'd1;
  localparam logic [1:0] LedGreen = 2'd2;
  localparam logic [1:0] LedBlue  = 2'd3;

  localparam logic [6:0] MaxKey = 7'd88;

  // ceil(2^24 / 15): exact floor division by 15 for any product below 2^20.
  localparam logic [20:0] Recip15 = 21'd1118482;

  typedef enum logic [1:0] {KindNop, KindTick, KindPause, KindWrite} kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [5:0]  idx;
    logic [6:0]  key;
    logic [7:0]  units;
  } cmd_t;

  typedef struct packed {
    logic        tick;
    logic        half;
    logic [4:0]  sidx;
    logic [15:0] load;
    logic [1:0]  lamp;
    logic        pause;
    logic [5:0]  note;
  } res_t;

  typedef struct packed {
    logic        sample_valid;
    logic [15:0] pwm;
    logic [1:0]  lamp;
    logic        pause;
    logic [5:0]  note;
  } out_t;

  localparam logic [3:0] SineRom [32] = '{
    4'd8, 4'd10, 4'd11, 4'd13, 4'd14, 4'd15, 4'd15, 4'd15,
    4'd15, 4'd15, 4'd14, 4'd13, 4'd11, 4'd10, 4'd8, 4'd6,
    4'd5, 4'd3, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
    4'd1, 4'd1, 4'd2, 4'd3, 4'd5, 4'd6, 4'd8, 4'd8
  };

  localparam logic [12:0] StepRom [89] = '{
    13'd0,
    13'd28, 13'd30, 13'd32, 13'd33, 13'd35, 13'd38, 13'd40, 13'd42,
    13'd45, 13'd47, 13'd50, 13'd53,
    13'd56, 13'd60, 13'd63, 13'd67, 13'd71, 13'd75, 13'd80, 13'd84,
    13'd89, 13'd95, 13'd100, 13'd106,
    13'd113, 13'd119, 13'd126, 13'd134, 13'd142, 13'd150, 13'd159, 13'd169,
    13'd179, 13'd189, 13'd201, 13'd213,
    13'd225, 13'd239, 13'd253, 13'd268, 13'd284, 13'd301, 13'd319, 13'd338,
    13'd358, 13'd379, 13'd401, 13'd425,
    13'd451, 13'd477, 13'd506, 13'd536, 13'd568, 13'd601, 13'd637, 13'd675,
    13'd715, 13'd758, 13'd803, 13'd851,
    13'd901, 13'd955, 13'd1011, 13'd1072, 13'd1135, 13'd1203, 13'd1274, 13'd1350,
    13'd1430, 13'd1515, 13'd1606, 13'd1701,
    13'd1802, 13'd1909, 13'd2023, 13'd2143, 13'd2271, 13'd2406, 13'd2549, 13'd2700,
    13'd2861, 13'd3031, 13'd3211, 13'd3402,
    13'd3604, 13'd3819, 13'd4046, 13'd4286
  };

  localparam logic [6:0] TuneKey [43] = '{
    7'd40, 7'd40, 7'd47, 7'd47, 7'd49, 7'd49, 7'd47,
    7'd45, 7'd45, 7'd44, 7'd44, 7'd42, 7'd42, 7'd40,
    7'd47, 7'd47, 7'd45, 7'd45, 7'd44, 7'd44, 7'd42,
    7'd47, 7'd47, 7'd45, 7'd45, 7'd44, 7'd44, 7'd42,
    7'd40, 7'd40, 7'd47, 7'd47, 7'd49, 7'd49, 7'd47,
    7'd45, 7'd45, 7'd44, 7'd44, 7'd42, 7'd42, 7'd40,
    7'd0
  };

  localparam logic [7:0] TuneUnits [43] = '{
    8'd5, 8'd5, 8'd5, 8'd5, 8'd5, 8'd5, 8'd10,
    8'd5, 8'd5, 8'd5, 8'd5, 8'd5, 8'd5, 8'd10,
    8'd5, 8'd5, 8'd5, 8'd5, 8'd5, 8'd5, 8'd10,
    8'd5, 8'd5, 8'd5, 8'd5, 8'd5, 8'd5, 8'd10,
    8'd5, 8'd5, 8'd5, 8'd5, 8'd5, 8'd5, 8'd10,
    8'd5, 8'd5, 8'd5, 8'd5, 8'd5, 8'd5, 8'd10,
    8'd0
  };

  function automatic logic [3:0] sine_of(input logic [4:0] idx);
    return SineRom[idx];
  endfunction

  // Keys above the top of the piano use the step of the top key.
  function automatic logic [12:0] step_of(input logic [6:0] key);
    logic [6:0] k;
    k = (key > MaxKey) ? MaxKey : key;
    return StepRom[k];
  endfunction

  function automatic logic [1:0] color_of(input logic [6:0] key);
    logic [1:0] c;
    unique case (key) inside
      7'd40, 7'd45: c = LedRed;
      7'd42, 7'd47: c = LedGreen;
      7'd44, 7'd49: c = LedBlue;
      default:      c = LedOff;
    endcase
    return c;
  endfunction

  // Song entry after reset: units in bits 14:7, key in bits 6:0.
  function automatic logic [14:0] tune_of(input logic [SongIdxW-1:0] a);
    logic [14:0] e;
    e = '0;
    if (a < SongIdxW'(TuneLen)) begin
      e = {TuneUnits[a], TuneKey[a]};
    end
    return e;
  endfunction

endpackage

>>> rtl/core/mts_front.sv
// Input side: takes items, classifies the command and queues them for the back end.
module mts_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  output logic           full_o,
  input  logic [1:0]     command_i,
  input  logic [7:0]     rx_byte_i,
  input  logic [5:0]     entry_index_i,
  input  logic [6:0]     entry_key_i,
  input  logic [7:0]     entry_units_i,
  output logic           cq_valid_o,
  output mts_pkg::cmd_t  cq_item_o,
  input  logic           cq_pop_i
);
  import mts_pkg::*;

  cmd_t               item_in;
  cmd_t               queue_q [CmdDepth];
  logic [CmdPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [CmdPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CmdPtrW:0]   cnt_q, cnt_d;
  logic               do_push;
  logic               do_pop;

  always_comb begin
    item_in.idx   = entry_index_i;
    item_in.key   = entry_key_i;
    item_in.units = entry_units_i;
    unique case (command_i)
      CmdTick:  item_in.kind = KindTick;
      CmdByte:  item_in.kind = (rx_byte_i == CharPLower || rx_byte_i == CharPUpper) ?
                               KindPause : KindNop;
      CmdWrite: item_in.kind = KindWrite;
      default:  item_in.kind = KindNop;
    endcase
  end

  assign full_o     = (cnt_q == (CmdPtrW+1)'(CmdDepth));
  assign cq_valid_o = (cnt_q != '0);
  assign cq_item_o  = queue_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = cq_pop_i && cq_valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + (CmdPtrW+1)'(do_push) - (CmdPtrW+1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      queue_q[wr_ptr_q] <= item_in;
    end
  end

endmodule

>>> rtl/core/mts_back.sv
// Back end: note sequencer, phase accumulator, song store and configuration registers.
module mts_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_index_i,
  input  logic [15:0]    cfg_wdata_i,
  input  logic           cq_valid_i,
  input  mts_pkg::cmd_t  cq_item_i,
  output logic           cq_pop_o,
  input  logic           out_ready_i,
  output logic           res_valid_o,
  output mts_pkg::res_t  res_o
);
  import mts_pkg::*;

  localparam logic [1:0] PhLoad = 2'd0;
  localparam logic [1:0] PhNote = 2'd1;
  localparam logic [1:0] PhRest = 2'd2;

  localparam logic SqRun  = 1'b0;
  localparam logic SqRead = 1'b1;

  // Why a song store read was issued.
  localparam logic [1:0] RdAdv   = 2'd0;
  localparam logic [1:0] RdLoad  = 2'd1;
  localparam logic [1:0] RdLoad0 = 2'd2;
  localparam logic [1:0] RdAdv2  = 2'd3;

  logic [15:0] load_q, note_unit_q, rest_q;
  logic [6:0]  play_len_q;

  logic        seq_q, seq_d;
  logic [1:0]  purpose_q, purpose_d;
  logic [1:0]  phase_q, phase_d;
  logic [12:0] acc_q, acc_d;
  logic [12:0] step_q, step_d;
  logic [5:0]  idx_q, idx_d;
  logic [23:0] tl_q, tl_d;
  logic        pause_q, pause_d;
  logic [1:0]  lamp_q, lamp_d;

  logic [14:0]         song_mem_q [SongDepth];
  logic [SongDepth-1:0] valid_q;
  logic [SongIdxW:0]   rd_addr_q, rd_addr_d;
  logic [14:0]         rd_data_q;
  logic                rd_valid_q;
  logic                rd_en;
  logic                mem_we;

  logic [14:0]         rd_entry;
  logic [6:0]          rd_key;
  logic [7:0]          rd_units;
  logic                rd_ok;
  logic [23:0]         note_len;
  logic [12:0]         rd_step;
  logic [SongIdxW:0]   idx_inc;
  logic [SongIdxW:0]   rd_inc;

  logic                emit;
  logic                res_valid_q;
  res_t                res_q, res_d;

  // Entries never written since reset read as the built-in tune.
  assign rd_entry = rd_valid_q ? rd_data_q : tune_of(rd_addr_q[SongIdxW-1:0]);
  assign rd_key   = rd_entry[6:0];
  assign rd_units = rd_entry[14:7];
  assign rd_ok    = !rd_addr_q[SongIdxW] && (rd_addr_q < play_len_q) && (rd_key != '0);
  assign note_len = 24'(rd_units) * 24'(note_unit_q);
  assign rd_step  = step_of(rd_key);
  assign idx_inc  = {1'b0, idx_q} + 1'b1;
  assign rd_inc   = rd_addr_q + 1'b1;

  always_comb begin
    seq_d     = seq_q;
    purpose_d = purpose_q;
    phase_d   = phase_q;
    acc_d     = acc_q;
    step_d    = step_q;
    idx_d     = idx_q;
    tl_d      = tl_q;
    pause_d   = pause_q;
    lamp_d    = lamp_q;
    rd_en     = 1'b0;
    rd_addr_d = rd_addr_q;
    mem_we    = 1'b0;
    cq_pop_o  = 1'b0;
    emit      = 1'b0;
    res_d     = res_q;
    res_d.tick = 1'b0;
    res_d.half = 1'b0;
    res_d.sidx = '0;
    res_d.load = load_q;

    unique case (seq_q)
      SqRun: begin
        if (cq_valid_i && out_ready_i) begin
          unique case (cq_item_i.kind)
            KindNop: begin
              cq_pop_o = 1'b1;
              emit     = 1'b1;
            end
            KindPause: begin
              pause_d  = !pause_q;
              cq_pop_o = 1'b1;
              emit     = 1'b1;
            end
            KindWrite: begin
              mem_we   = 1'b1;
              cq_pop_o = 1'b1;
              emit     = 1'b1;
            end
            KindTick: begin
              res_d.tick = 1'b1;
              if (pause_q) begin
                res_d.half = 1'b1;
                cq_pop_o   = 1'b1;
                emit       = 1'b1;
              end else if (phase_q == PhNote && tl_q != '0) begin
                res_d.sidx = acc_q[12:8];
                acc_d      = acc_q + step_q;
                tl_d       = tl_q - 1'b1;
                cq_pop_o   = 1'b1;
                emit       = 1'b1;
              end else if (phase_q == PhRest && tl_q != '0) begin
                res_d.half = 1'b1;
                tl_d       = tl_q - 1'b1;
                cq_pop_o   = 1'b1;
                emit       = 1'b1;
              end else if (phase_q == PhNote) begin
                // The note has ended: enter its rest.
                phase_d = PhRest;
                acc_d   = '0;
                lamp_d  = LedOff;
                if (rest_q != '0) begin
                  tl_d       = {8'b0, rest_q} - 24'd1;
                  res_d.half = 1'b1;
                  cq_pop_o   = 1'b1;
                  emit       = 1'b1;
                end else begin
                  tl_d      = '0;
                  rd_en     = 1'b1;
                  rd_addr_d = idx_inc;
                  purpose_d = RdAdv;
                  seq_d     = SqRead;
                end
              end else if (phase_q == PhRest) begin
                rd_en     = 1'b1;
                rd_addr_d = idx_inc;
                purpose_d = RdAdv;
                seq_d     = SqRead;
              end else begin
                rd_en     = 1'b1;
                rd_addr_d = {1'b0, idx_q};
                purpose_d = RdLoad;
                seq_d     = SqRead;
              end
            end
          endcase
        end
      end
      SqRead: begin
        res_d.tick = 1'b1;
        if (purpose_q == RdAdv2) begin
          // Second advance of the same tick: no further load in this tick.
          idx_d      = rd_ok ? rd_addr_q[SongIdxW-1:0] : '0;
          phase_d    = PhLoad;
          res_d.half = 1'b1;
          cq_pop_o   = 1'b1;
          emit       = 1'b1;
          seq_d      = SqRun;
        end else if (rd_ok) begin
          idx_d  = rd_addr_q[SongIdxW-1:0];
          step_d = rd_step;
          if (note_len != '0) begin
            phase_d  = PhNote;
            lamp_d   = color_of(rd_key);
            acc_d    = rd_step;
            tl_d     = note_len - 24'd1;
            cq_pop_o = 1'b1;
            emit     = 1'b1;
            seq_d    = SqRun;
          end else begin
            // A note of no length goes straight to its rest.
            phase_d = PhRest;
            acc_d   = '0;
            lamp_d  = LedOff;
            if (rest_q != '0) begin
              tl_d       = {8'b0, rest_q} - 24'd1;
              res_d.half = 1'b1;
              cq_pop_o   = 1'b1;
              emit       = 1'b1;
              seq_d      = SqRun;
            end else begin
              tl_d      = '0;
              rd_en     = 1'b1;
              rd_addr_d = rd_inc;
              purpose_d = RdAdv2;
            end
          end
        end else if (purpose_q == RdLoad0) begin
          // Not even the first entry is playable: stay idle.
          idx_d      = '0;
          phase_d    = PhLoad;
          res_d.half = 1'b1;
          cq_pop_o   = 1'b1;
          emit       = 1'b1;
          seq_d      = SqRun;
        end else begin
          idx_d     = '0;
          phase_d   = PhLoad;
          rd_en     = 1'b1;
          rd_addr_d = '0;
          purpose_d = RdLoad0;
        end
      end
    endcase

    res_d.lamp  = lamp_d;
    res_d.pause = pause_d;
    res_d.note  = idx_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_q      <= PwmLoadReset;
      note_unit_q <= NoteUnitReset;
      rest_q      <= RestTicksReset;
      play_len_q  <= SongLengthReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgPwmLoad:    load_q      <= cfg_wdata_i;
        CfgNoteUnit:   note_unit_q <= cfg_wdata_i;
        CfgRestTicks:  rest_q      <= cfg_wdata_i;
        CfgSongLength: play_len_q  <= cfg_wdata_i[6:0];
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q       <= SqRun;
      purpose_q   <= RdAdv;
      phase_q     <= PhLoad;
      acc_q       <= '0;
      step_q      <= '0;
      idx_q       <= '0;
      tl_q        <= '0;
      pause_q     <= 1'b0;
      lamp_q      <= LedOff;
      valid_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      seq_q       <= seq_d;
      purpose_q   <= purpose_d;
      phase_q     <= phase_d;
      acc_q       <= acc_d;
      step_q      <= step_d;
      idx_q       <= idx_d;
      tl_q        <= tl_d;
      pause_q     <= pause_d;
      lamp_q      <= lamp_d;
      res_valid_q <= emit;
      if (mem_we) begin
        valid_q[cq_item_i.idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (mem_we) begin
      song_mem_q[cq_item_i.idx] <= {cq_item_i.units, cq_item_i.key};
    end
    if (rd_en) begin
      rd_addr_q  <= rd_addr_d;
      rd_data_q  <= song_mem_q[rd_addr_d[SongIdxW-1:0]];
      rd_valid_q <= valid_q[rd_addr_d[SongIdxW-1:0]];
    end
  end

endmodule

>>> rtl/core/mts_out.sv
// Result side: PWM compare arithmetic in two stages and the result queue.
module mts_out (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  mts_pkg::res_t  in_res_i,
  output logic           ready_o,
  output logic           empty_o,
  input  logic           pop_i,
  output mts_pkg::out_t  out_item_o
);
  import mts_pkg::*;

  logic               s1_valid_q;
  res_t               s1_res_q;
  logic [19:0]        s1_x_q;
  logic [19:0]        x_d;
  logic [40:0]        prod;
  logic [15:0]        quot;
  out_t               wr_item;

  out_t               fifo_q [OutDepth];
  logic [OutPtrW-1:0] wr_ptr_q;
  logic [OutPtrW-1:0] rd_ptr_q;
  logic [OutPtrW:0]   cnt_q, cnt_d;
  logic [OutPtrW+1:0] occ;
  logic               do_pop;

  assign x_d  = 20'(in_res_i.load) * 20'(sine_of(in_res_i.sidx));
  assign prod = 41'(s1_x_q) * 41'(Recip15);
  assign quot = prod[39:24];

  always_comb begin
    wr_item.sample_valid = s1_res_q.tick;
    wr_item.lamp         = s1_res_q.lamp;
    wr_item.pause        = s1_res_q.pause;
    wr_item.note         = s1_res_q.note;
    if (!s1_res_q.tick) begin
      wr_item.pwm = '0;
    end else if (s1_res_q.half) begin
      wr_item.pwm = {1'b0, s1_res_q.load[15:1]};
    end else begin
      wr_item.pwm = s1_res_q.load - quot;
    end
  end

  // Every item in flight already holds a queue slot, so a write never finds it full.
  assign occ     = (OutPtrW+2)'(cnt_q) + (OutPtrW+2)'(in_valid_i) + (OutPtrW+2)'(s1_valid_q);
  assign ready_o = (occ < (OutPtrW+2)'(OutDepth));

  assign empty_o    = (cnt_q == '0);
  assign out_item_o = fifo_q[rd_ptr_q];
  assign do_pop     = pop_i && !empty_o;
  assign cnt_d      = cnt_q + (OutPtrW+1)'(s1_valid_q) - (OutPtrW+1)'(do_pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      cnt_q      <= '0;
    end else begin
      s1_valid_q <= in_valid_i;
      cnt_q      <= cnt_d;
      if (s1_valid_q) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_res_q <= in_res_i;
    s1_x_q   <= x_d;
    if (s1_valid_q) begin
      fifo_q[wr_ptr_q] <= wr_item;
    end
  end

endmodule

>>> rtl/core/melody_tone_sequencer_top.sv
// Top level of the melody tone sequencer: front end, back end and result side.
//
// Channel   Dir  Handshake         Payload
// input     in   push / full       command_i, rx_byte_i, entry_index_i, entry_key_i,
//                                  entry_units_i
// result    out  empty / pop       sample_valid_o, pwm_compare_o, led_color_o,
//                                  is_paused_o, current_note_o
// config    in   cfg_we_i          cfg_index_i, cfg_wdata_i
//
// Most items need no song store read, so one item per cycle is sustained while the result queue has room.
// A tick that needs the song store (a rest that ends, a note that ends with no rest,
// or a load) holds the back end while it issues its registered song store reads.
// A result passes the back-end result register, the result side's first stage and the result queue.
// Reset restores the register defaults; unwritten song entries read as the built-in tune.
// The back end starts an item only when the four-entry result queue has a slot for it.
module melody_tone_sequencer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  command_i,
  input  logic [7:0]  rx_byte_i,
  input  logic [5:0]  entry_index_i,
  input  logic [6:0]  entry_key_i,
  input  logic [7:0]  entry_units_i,
  output logic        empty,
  input  logic        pop,
  output logic        sample_valid_o,
  output logic [15:0] pwm_compare_o,
  output logic [1:0]  led_color_o,
  output logic        is_paused_o,
  output logic [5:0]  current_note_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_wdata_i
);
  import mts_pkg::*;

  logic  cq_valid;
  cmd_t  cq_item;
  logic  cq_pop;
  logic  res_valid;
  res_t  res;
  logic  out_ready;
  out_t  out_item;

  mts_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_o        (full),
    .command_i     (command_i),
    .rx_byte_i     (rx_byte_i),
    .entry_index_i (entry_index_i),
    .entry_key_i   (entry_key_i),
    .entry_units_i (entry_units_i),
    .cq_valid_o    (cq_valid),
    .cq_item_o     (cq_item),
    .cq_pop_i      (cq_pop)
  );

  mts_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cq_valid_i  (cq_valid),
    .cq_item_i   (cq_item),
    .cq_pop_o    (cq_pop),
    .out_ready_i (out_ready),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  mts_out u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (res_valid),
    .in_res_i   (res),
    .ready_o    (out_ready),
    .empty_o    (empty),
    .pop_i      (pop),
    .out_item_o (out_item)
  );

  assign sample_valid_o = out_item.sample_valid;
  assign pwm_compare_o  = out_item.pwm;
  assign led_color_o    = out_item.lamp;
  assign is_paused_o    = out_item.pause;
  assign current_note_o = out_item.note;

endmodule
